>>> hw/rtl/wkbp_pkg.sv
// shared types and constants for the wkb geometry stream parser
// depends on nothing; used by wkbp_parser, wkbp_rsp_queue and the top level

package wkbp_pkg;

   // parse phase, one-hot
   typedef enum logic [7:0] {
      PH_IDLE   = 8'b0000_0001,
      PH_TYPE   = 8'b0000_0010,
      PH_OUTER  = 8'b0000_0100,
      PH_HEADER = 8'b0000_1000,
      PH_RINGS  = 8'b0001_0000,
      PH_POINTS = 8'b0010_0000,
      PH_X      = 8'b0100_0000,
      PH_Y      = 8'b1000_0000
   } phase_type;

   // geometry type codes
   localparam logic [2:0] GeomNone            = 3'd0;
   localparam logic [2:0] GeomPoint           = 3'd1;
   localparam logic [2:0] GeomLineString      = 3'd2;
   localparam logic [2:0] GeomPolygon         = 3'd3;
   localparam logic [2:0] GeomMultiPoint      = 3'd4;
   localparam logic [2:0] GeomMultiLineString = 3'd5;
   localparam logic [2:0] GeomMultiPolygon    = 3'd6;

   // result codes
   localparam logic       StatusVertex      = 1'b0;
   localparam logic       StatusUnsupported = 1'b1;
   localparam logic       CmdMoveTo         = 1'b0;
   localparam logic       CmdLineTo         = 1'b1;
   localparam logic [1:0] KindPoint         = 2'd0;
   localparam logic [1:0] KindLine          = 2'd1;
   localparam logic [1:0] KindRing          = 2'd2;

   // byte-order byte value that selects big endian
   localparam logic [7:0] ByteOrderBig = 8'h00;

   // index of the final byte of a field, and of a sub-geometry header
   localparam logic [2:0] WordLastByte  = 3'd3;
   localparam logic [2:0] CoordLastByte = 3'd7;
   localparam logic [2:0] HeaderLast    = 3'd4;

   // one result item
   typedef struct packed {
      logic        status;
      logic        command;
      logic [1:0]  part_kind;
      logic [63:0] x_bits;
      logic [63:0] y_bits;
      logic        geometry_end;
      logic        last;
   } rsp_type;

endpackage

>>> hw/rtl/wkb_geometry_stream_parser.sv
// wkb geometry stream parser: one record byte per transaction in, vertex commands out
// results: each result is written into the result queue and is offered on rsp from there
// throughput: one byte per cycle; results leave at one per cycle while rsp_tready is high, from a four-entry queue,
// and req_tready drops while the queue holds three or more results
// reset: synchronous, clears the parse phase and the queue; no clearing pass
// depends on wkbp_pkg, wkbp_parser and wkbp_rsp_queue

module wkb_geometry_stream_parser #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] data_byte
   input  logic         req_tuser,   // [0] record_start
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata,   // [0] command, [2:1] part_kind, [66:3] x_bits,
                                     // [130:67] y_bits, [131] geometry_end, [135:132] zero
   output logic         rsp_tuser,   // [0] status
   output logic         rsp_tlast    // last result of the input byte
);

   logic              req_accept;
   logic              rsp_accept;
   wkbp_pkg::rsp_type res_a;
   wkbp_pkg::rsp_type res_b;
   logic [1:0]        res_count;
   wkbp_pkg::rsp_type head;

   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = rsp_tvalid && rsp_tready;

   // parse state and step logic
   wkbp_parser #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .step_en      (req_accept),
      .data_byte    (req_tdata),
      .record_start (req_tuser),
      .res_a        (res_a),
      .res_b        (res_b),
      .res_count    (res_count)
   );

   // result buffering between the two sides
   wkbp_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (res_count),
      .push_a     (res_a),
      .push_b     (res_b),
      .pop        (rsp_accept),
      .space_ok   (req_tready),
      .head_valid (rsp_tvalid),
      .head       (head)
   );

   // result packing
   assign rsp_tdata = {4'b0000, head.geometry_end, head.y_bits, head.x_bits,
                       head.part_kind, head.command};
   assign rsp_tuser = head.status;
   assign rsp_tlast = head.last;

endmodule

>>> hw/rtl/wkbp_parser.sv
// byte-wise parse state and step logic for the wkb geometry stream parser
// depends on wkbp_pkg; gives up to two result items per accepted byte

module wkbp_parser #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step_en,
   input  logic [7:0]       data_byte,
   input  logic             record_start,
   output wkbp_pkg::rsp_type res_a,
   output wkbp_pkg::rsp_type res_b,
   output logic [1:0]       res_count
);

   localparam logic [31:0] CountMax = 32'((64'd1 << COUNT_WIDTH) - 64'd1);
   localparam logic [COUNT_WIDTH-1:0] CountOne  = COUNT_WIDTH'(1);
   localparam logic [COUNT_WIDTH-1:0] CountZero = '0;

   // state registers
   wkbp_pkg::phase_type     phase_ff, phase_in;
   logic                    big_ff, big_in;
   logic [2:0]              gtype_ff, gtype_in;
   logic [63:0]             shift_ff, shift_in;
   logic [2:0]              cnt_ff, cnt_in;
   logic [2:0]              skip_ff, skip_in;
   logic [COUNT_WIDTH-1:0]  outer_ff, outer_in;
   logic [COUNT_WIDTH-1:0]  ring_ff, ring_in;
   logic [COUNT_WIDTH-1:0]  point_ff, point_in;
   logic [63:0]             held_x_ff, held_x_in;
   logic [63:0]             first_x_ff, first_x_in;
   logic [63:0]             first_y_ff, first_y_in;
   logic                    first_ff, first_in;

   // field assembly
   logic                    coord_phase;
   logic                    field_phase;
   logic [2:0]              last_byte;
   logic                    fld_done;
   logic [63:0]             acc;
   logic [31:0]             word32;
   logic [COUNT_WIDTH-1:0]  sat_cnt;
   logic [1:0]              kind;

   // end-of-part bookkeeping
   logic [COUNT_WIDTH-1:0]  outer_dec;
   logic [COUNT_WIDTH-1:0]  ring_dec;
   logic [COUNT_WIDTH-1:0]  point_dec;
   wkbp_pkg::phase_type     od_phase;
   wkbp_pkg::phase_type     rd_phase;
   logic [COUNT_WIDTH-1:0]  rd_outer;
   wkbp_pkg::phase_type     pd_phase;
   logic [COUNT_WIDTH-1:0]  pd_ring;
   logic [COUNT_WIDTH-1:0]  pd_outer;

   logic [1:0]              n_res;

   // byte assembly into the current field
   assign coord_phase = (phase_ff == wkbp_pkg::PH_X) || (phase_ff == wkbp_pkg::PH_Y);
   assign field_phase = coord_phase || (phase_ff == wkbp_pkg::PH_TYPE) ||
                        (phase_ff == wkbp_pkg::PH_OUTER) ||
                        (phase_ff == wkbp_pkg::PH_RINGS) ||
                        (phase_ff == wkbp_pkg::PH_POINTS);
   assign last_byte = coord_phase ? wkbp_pkg::CoordLastByte : wkbp_pkg::WordLastByte;
   assign fld_done  = (cnt_ff >= last_byte);
   assign acc = big_ff ? {shift_ff[55:0], data_byte}
                       : (shift_ff | (64'(data_byte) << {cnt_ff, 3'b000}));
   assign word32  = acc[31:0];
   assign sat_cnt = (word32 > CountMax) ? CountMax[COUNT_WIDTH-1:0]
                                        : word32[COUNT_WIDTH-1:0];

   // part kind from geometry type
   always_comb begin
      case (gtype_ff)
         wkbp_pkg::GeomLineString, wkbp_pkg::GeomMultiLineString: kind = wkbp_pkg::KindLine;
         wkbp_pkg::GeomPolygon, wkbp_pkg::GeomMultiPolygon:       kind = wkbp_pkg::KindRing;
         default:                                                 kind = wkbp_pkg::KindPoint;
      endcase
   end

   // saturating decrements
   assign outer_dec = (outer_ff != CountZero) ? outer_ff - CountOne : CountZero;
   assign ring_dec  = (ring_ff != CountZero) ? ring_ff - CountOne : CountZero;
   assign point_dec = (point_ff != CountZero) ? point_ff - CountOne : CountZero;

   // next phase when an outer member, a polygon or a part is finished
   always_comb begin
      od_phase = (outer_dec != CountZero) ? wkbp_pkg::PH_HEADER : wkbp_pkg::PH_IDLE;
      if (gtype_ff == wkbp_pkg::GeomMultiPolygon) begin
         rd_phase = od_phase;
         rd_outer = outer_dec;
      end else begin
         rd_phase = wkbp_pkg::PH_IDLE;
         rd_outer = outer_ff;
      end
      pd_ring  = ring_ff;
      pd_outer = outer_ff;
      case (gtype_ff)
         wkbp_pkg::GeomPolygon, wkbp_pkg::GeomMultiPolygon: begin
            pd_ring = ring_dec;
            if (ring_dec != CountZero) begin
               pd_phase = wkbp_pkg::PH_POINTS;
            end else begin
               pd_phase = rd_phase;
               pd_outer = rd_outer;
            end
         end
         wkbp_pkg::GeomMultiPoint, wkbp_pkg::GeomMultiLineString: begin
            pd_phase = od_phase;
            pd_outer = outer_dec;
         end
         default: pd_phase = wkbp_pkg::PH_IDLE;
      endcase
   end

   // header bytes are counted only while skipping
   assign skip_in = ((phase_ff == wkbp_pkg::PH_HEADER) && (skip_ff < wkbp_pkg::HeaderLast))
                    ? skip_ff + 3'd1 : 3'd0;

   // one step of the parser
   always_comb begin
      phase_in   = phase_ff;
      big_in     = big_ff;
      gtype_in   = gtype_ff;
      shift_in   = shift_ff;
      cnt_in     = cnt_ff;
      outer_in   = outer_ff;
      ring_in    = ring_ff;
      point_in   = point_ff;
      held_x_in  = held_x_ff;
      first_x_in = first_x_ff;
      first_y_in = first_y_ff;
      first_in   = first_ff;
      n_res      = 2'd0;
      res_a = '{status: wkbp_pkg::StatusVertex, command: wkbp_pkg::CmdMoveTo,
                part_kind: wkbp_pkg::KindPoint, x_bits: 64'd0, y_bits: 64'd0,
                geometry_end: 1'b0, last: 1'b0};
      res_b = '{status: wkbp_pkg::StatusVertex, command: wkbp_pkg::CmdLineTo,
                part_kind: wkbp_pkg::KindRing, x_bits: 64'd0, y_bits: 64'd0,
                geometry_end: 1'b0, last: 1'b0};

      if (field_phase) begin
         if (fld_done) begin
            shift_in = 64'd0;
            cnt_in   = 3'd0;
         end else begin
            shift_in = acc;
            cnt_in   = cnt_ff + 3'd1;
         end
      end

      if (record_start) begin
         // new record: byte order, then the type word
         phase_in = wkbp_pkg::PH_TYPE;
         big_in   = (data_byte == wkbp_pkg::ByteOrderBig);
         gtype_in = wkbp_pkg::GeomNone;
         shift_in = 64'd0;
         cnt_in   = 3'd0;
         first_in = 1'b1;
      end else begin
         case (phase_ff)
            wkbp_pkg::PH_TYPE: begin
               if (fld_done) begin
                  if (word32 inside {[32'd1:32'd6]}) begin
                     gtype_in = word32[2:0];
                     case (word32[2:0])
                        wkbp_pkg::GeomPoint: begin
                           point_in = CountOne;
                           first_in = 1'b1;
                           phase_in = wkbp_pkg::PH_X;
                        end
                        wkbp_pkg::GeomLineString: phase_in = wkbp_pkg::PH_POINTS;
                        wkbp_pkg::GeomPolygon:    phase_in = wkbp_pkg::PH_RINGS;
                        default:                  phase_in = wkbp_pkg::PH_OUTER;
                     endcase
                  end else begin
                     gtype_in     = wkbp_pkg::GeomNone;
                     res_a.status = wkbp_pkg::StatusUnsupported;
                     n_res        = 2'd1;
                     phase_in     = wkbp_pkg::PH_IDLE;
                  end
               end
            end
            wkbp_pkg::PH_OUTER: begin
               if (fld_done) begin
                  outer_in = sat_cnt;
                  phase_in = (sat_cnt == CountZero) ? wkbp_pkg::PH_IDLE : wkbp_pkg::PH_HEADER;
               end
            end
            wkbp_pkg::PH_HEADER: begin
               if (skip_ff >= wkbp_pkg::HeaderLast) begin
                  case (gtype_ff)
                     wkbp_pkg::GeomMultiPoint: begin
                        point_in = CountOne;
                        first_in = 1'b1;
                        phase_in = wkbp_pkg::PH_X;
                     end
                     wkbp_pkg::GeomMultiLineString: phase_in = wkbp_pkg::PH_POINTS;
                     default:                       phase_in = wkbp_pkg::PH_RINGS;
                  endcase
               end
            end
            wkbp_pkg::PH_RINGS: begin
               if (fld_done) begin
                  ring_in = sat_cnt;
                  if (sat_cnt == CountZero) begin
                     phase_in = rd_phase;
                     outer_in = rd_outer;
                  end else begin
                     phase_in = wkbp_pkg::PH_POINTS;
                  end
               end
            end
            wkbp_pkg::PH_POINTS: begin
               if (fld_done) begin
                  point_in = sat_cnt;
                  first_in = 1'b1;
                  if (sat_cnt == CountZero) begin
                     // empty part emits nothing
                     phase_in = pd_phase;
                     ring_in  = pd_ring;
                     outer_in = pd_outer;
                  end else begin
                     phase_in = wkbp_pkg::PH_X;
                  end
               end
            end
            wkbp_pkg::PH_X: begin
               if (fld_done) begin
                  held_x_in = acc;
                  phase_in  = wkbp_pkg::PH_Y;
               end
            end
            wkbp_pkg::PH_Y: begin
               if (fld_done) begin
                  res_a.command   = first_ff ? wkbp_pkg::CmdMoveTo : wkbp_pkg::CmdLineTo;
                  res_a.part_kind = kind;
                  res_a.x_bits    = held_x_ff;
                  res_a.y_bits    = acc;
                  n_res           = 2'd1;
                  if (first_ff) begin
                     first_x_in = held_x_ff;
                     first_y_in = acc;
                  end
                  first_in = 1'b0;
                  point_in = point_dec;
                  if (point_dec == CountZero) begin
                     // ring closes on its first point
                     if (kind == wkbp_pkg::KindRing) begin
                        res_b.x_bits = first_x_in;
                        res_b.y_bits = first_y_in;
                        n_res        = 2'd2;
                     end
                     phase_in = pd_phase;
                     ring_in  = pd_ring;
                     outer_in = pd_outer;
                  end else begin
                     phase_in = wkbp_pkg::PH_X;
                  end
               end
            end
            default: phase_in = wkbp_pkg::PH_IDLE;
         endcase
      end

      // mark the last result of this byte and the end of the record
      if (n_res == 2'd1) begin
         res_a.last         = 1'b1;
         res_a.geometry_end = (phase_in == wkbp_pkg::PH_IDLE);
      end else if (n_res == 2'd2) begin
         res_b.last         = 1'b1;
         res_b.geometry_end = (phase_in == wkbp_pkg::PH_IDLE);
      end
   end

   assign res_count = step_en ? n_res : 2'd0;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= wkbp_pkg::PH_IDLE;
         big_ff   <= 1'b0;
         gtype_ff <= wkbp_pkg::GeomNone;
         shift_ff <= 64'd0;
         cnt_ff   <= 3'd0;
         skip_ff  <= 3'd0;
         first_ff <= 1'b1;
      end else if (step_en) begin
         phase_ff <= phase_in;
         big_ff   <= big_in;
         gtype_ff <= gtype_in;
         shift_ff <= shift_in;
         cnt_ff   <= cnt_in;
         skip_ff  <= skip_in;
         first_ff <= first_in;
      end
   end

   // counts and coordinates, always written before they are read
   always_ff @(posedge clock) begin
      if (step_en) begin
         outer_ff   <= outer_in;
         ring_ff    <= ring_in;
         point_ff   <= point_in;
         held_x_ff  <= held_x_in;
         first_x_ff <= first_x_in;
         first_y_ff <= first_y_in;
      end
   end

endmodule

>>> hw/rtl/wkbp_rsp_queue.sv
// four-entry result queue with two write slots and one read port
// depends on wkbp_pkg for the result item type

module wkbp_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic [1:0]        push_count,
   input  wkbp_pkg::rsp_type push_a,
   input  wkbp_pkg::rsp_type push_b,
   input  logic              pop,
   output logic              space_ok,
   output logic              head_valid,
   output wkbp_pkg::rsp_type head
);

   wkbp_pkg::rsp_type slot_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;

   // pointer and fill bookkeeping
   assign wr_ptr_in = wr_ptr_ff + push_count;
   assign rd_ptr_in = rd_ptr_ff + {1'b0, pop};
   assign count_in  = count_ff + {1'b0, push_count} - {2'b00, pop};

   // room for two more results whatever the read side does
   assign space_ok   = (count_ff <= 3'd2);
   assign head_valid = (count_ff != 3'd0);
   assign head       = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // result storage
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         slot_ff[wr_ptr_ff] <= push_a;
      end
      if (push_count == 2'd2) begin
         slot_ff[wr_ptr_ff + 2'd1] <= push_b;
      end
   end

endmodule
